/* rtl/core/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths and types for the triangle scanline span unit.
// ----------------------------------------------------------------------------
package tss_pkg;

    // Width of every coordinate.
    localparam int CB = 12;
    // Depth of the queue between the front and the back part.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One edge that is ready to be evaluated on the row.
    typedef struct packed {
        logic [CB-1:0] xs;    // x of the start vertex
        logic [CB-1:0] dxm;   // magnitude of the x change along the edge
        logic          neg;   // x decreases along the edge
        logic [CB-1:0] t;     // row minus start y
        logic [CB-1:0] dy;    // y extent of the edge, never zero
    } t_edge;

    // One classified word as it waits in the queue.
    typedef struct packed {
        logic  covered;
        t_edge short_e;
        t_edge long_e;
    } t_job;

endpackage

/* rtl/core/tss_front.sv */
// ----------------------------------------------------------------------------
// tss_front
// Sorts the vertices by y, checks the row and picks the short and long edges.
// ----------------------------------------------------------------------------
module tss_front
    import tss_pkg::*;
(
    input  logic [CB-1:0] i_apex_x,
    input  logic [CB-1:0] i_apex_y,
    input  logic [CB-1:0] i_first_x,
    input  logic [CB-1:0] i_first_y,
    input  logic [CB-1:0] i_second_x,
    input  logic [CB-1:0] i_second_y,
    input  logic [CB-1:0] i_row_y,
    output t_job          o_job
);

    logic [CB-1:0] x0, y0, x1, y1, x2, y2;
    logic          cov;

    // Build one edge record; an uncovered row collapses to a zero result.
    function automatic t_edge make_edge(input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                                        input logic [CB-1:0] xe, input logic [CB-1:0] ye,
                                        input logic [CB-1:0] row, input logic c);
        t_edge e;
        e.neg = (xe < xs);
        e.dxm = e.neg ? (xs - xe) : (xe - xs);
        e.t   = row - ys;
        e.dy  = (ye == ys) ? CB'(1) : (ye - ys);
        e.xs  = xs;
        if (!c) begin
            e.xs  = '0;
            e.dxm = '0;
            e.t   = '0;
            e.dy  = CB'(1);
            e.neg = 1'b0;
        end
        return e;
    endfunction

    // Sort the vertices by y; tied vertices do not always keep their input order.
    always_comb begin
        if (i_apex_y > i_first_y && i_apex_y > i_second_y) begin
            x2 = i_apex_x; y2 = i_apex_y;
            if (i_first_y > i_second_y) begin
                x0 = i_second_x; y0 = i_second_y; x1 = i_first_x; y1 = i_first_y;
            end else begin
                x0 = i_first_x; y0 = i_first_y; x1 = i_second_x; y1 = i_second_y;
            end
        end else if (i_apex_y < i_first_y && i_apex_y < i_second_y) begin
            x0 = i_apex_x; y0 = i_apex_y;
            if (i_second_y > i_first_y) begin
                x1 = i_first_x; y1 = i_first_y; x2 = i_second_x; y2 = i_second_y;
            end else begin
                x1 = i_second_x; y1 = i_second_y; x2 = i_first_x; y2 = i_first_y;
            end
        end else begin
            x1 = i_apex_x; y1 = i_apex_y;
            if (i_second_y > i_first_y) begin
                x0 = i_first_x; y0 = i_first_y; x2 = i_second_x; y2 = i_second_y;
            end else begin
                x0 = i_second_x; y0 = i_second_y; x2 = i_first_x; y2 = i_first_y;
            end
        end
    end

    // Pick the edges for this row.
    always_comb begin
        cov = (i_row_y >= y0) && (i_row_y <= y2);
        o_job.covered = cov;
        if (i_row_y <= y1) begin
            o_job.short_e = make_edge(x0, y0, x1, y1, i_row_y, cov);
        end else begin
            o_job.short_e = make_edge(x1, y1, x2, y2, i_row_y, cov);
        end
        o_job.long_e = make_edge(x0, y0, x2, y2, i_row_y, cov);
    end

endmodule

/* rtl/core/tss_queue.sv */
// ----------------------------------------------------------------------------
// tss_queue
// Short queue of classified words between the front and the back part.
// ----------------------------------------------------------------------------
module tss_queue
    import tss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty,
    output logic o_full
);

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/tss_edge.sv */
// ----------------------------------------------------------------------------
// tss_edge
// Pipelined edge intercept: one multiply stage, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module tss_edge
    import tss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  t_edge         i_edge,
    output logic [CB-1:0] o_x
);

    logic [CB-1:0] r_rem [CB+1];
    logic [CB-1:0] r_low [CB+1];
    logic [CB-1:0] r_q   [CB+1];
    logic [CB-1:0] r_dy  [CB+1];
    logic [CB-1:0] r_xs  [CB+1];
    logic          r_neg [CB+1];
    logic [2*CB-1:0] prod;
    logic [CB:0]     trial [CB];
    logic            fit   [CB];

    assign prod = {{CB{1'b0}}, i_edge.dxm} * {{CB{1'b0}}, i_edge.t};

    // Trial subtraction of each division stage.
    always_comb begin
        for (int k = 0; k < CB; k++) begin
            trial[k] = {r_rem[k], r_low[k][CB-1]};
            fit[k]   = (trial[k] >= {1'b0, r_dy[k]});
        end
    end

    // Multiply stage and restoring division stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= prod[2*CB-1:CB];
            r_low[0] <= prod[CB-1:0];
            r_q[0]   <= '0;
            r_dy[0]  <= i_edge.dy;
            r_xs[0]  <= i_edge.xs;
            r_neg[0] <= i_edge.neg;
            for (int k = 0; k < CB; k++) begin
                r_rem[k+1] <= fit[k] ? CB'(trial[k] - {1'b0, r_dy[k]}) : trial[k][CB-1:0];
                r_low[k+1] <= {r_low[k][CB-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][CB-2:0], fit[k]};
                r_dy[k+1]  <= r_dy[k];
                r_xs[k+1]  <= r_xs[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // Floor toward minus infinity on a falling edge.
    assign o_x = r_neg[CB]
               ? (r_xs[CB] - r_q[CB] - CB'(r_rem[CB] != '0))
               : (r_xs[CB] + r_q[CB]);

endmodule

/* rtl/core/triangle_scanline_span_unit.sv */
// ----------------------------------------------------------------------------
// triangle_scanline_span_unit
// Span ends of one triangle on one scanline row.
// ----------------------------------------------------------------------------
// Input channel: i_valid with o_stall; a word carries three vertices and a
// row, and is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid with i_stall; a word carries o_covered and the
// x ends on the short and on the long edge (both zero when not covered).
// Throughput: one word per cycle unless the receiver stalls. The front
// classifies in the accept cycle, a four-entry queue follows, then each
// edge runs through one multiply stage and twelve divider stages (one
// quotient bit each), then an output register.
// When the receiver stalls, the output word holds and the divider pipeline
// freezes; the queue keeps taking words until it is full, then o_stall rises.
// Reset (synchronous, active low) empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module triangle_scanline_span_unit
    import tss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [CB-1:0] i_apex_x,
    input  logic [CB-1:0] i_apex_y,
    input  logic [CB-1:0] i_first_x,
    input  logic [CB-1:0] i_first_y,
    input  logic [CB-1:0] i_second_x,
    input  logic [CB-1:0] i_second_y,
    input  logic [CB-1:0] i_row_y,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_covered,
    output logic [CB-1:0] o_short_edge_x,
    output logic [CB-1:0] o_long_edge_x
);

    t_job          front_job, q_job;
    logic          q_empty, q_full, push, pop, adv;
    logic [CB:0]   r_vld, r_cov;
    logic [CB-1:0] sx, lx;
    logic          r_out_valid, r_out_cov;
    logic [CB-1:0] r_out_sx, r_out_lx;

    // The pipeline moves whenever the output register can take a word.
    assign adv     = !r_out_valid || !i_stall;
    assign push    = i_valid && !q_full;
    assign pop     = adv && !q_empty;
    assign o_stall = q_full;

    tss_front u_front (
        .i_apex_x   (i_apex_x),
        .i_apex_y   (i_apex_y),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_row_y    (i_row_y),
        .o_job      (front_job)
    );

    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (q_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tss_edge u_short (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_edge (q_job.short_e),
        .o_x    (sx)
    );

    tss_edge u_long (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_edge (q_job.long_e),
        .o_x    (lx)
    );

    // Valid and covered flags travel beside the edge pipelines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[CB-1:0], pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cov <= {r_cov[CB-1:0], q_job.covered};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cov <= r_cov[CB];
            r_out_sx  <= sx;
            r_out_lx  <= lx;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_covered      = r_out_cov;
    assign o_short_edge_x = r_out_sx;
    assign o_long_edge_x  = r_out_lx;

    // An uncovered row always reports zero span ends.
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_covered) |-> (o_short_edge_x == '0 && o_long_edge_x == '0))
        else $error("uncovered row with nonzero span end");

    // A stalled output freezes the divider pipeline.
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved under output stall");

    // Nothing leaves the queue while the output is blocked.
    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !pop)
        else $error("queue popped under output stall");

endmodule
